/* sv/lscm_pkg.sv */
package lscm_pkg;

  localparam int IN_W      = 336;
  localparam int OUT_W     = 56;
  localparam int POS_W     = 32;
  localparam int ID_W      = 16;
  localparam int COL_W     = 17;
  localparam int COEF_W    = 32;
  localparam int EDGE_W    = 33;
  localparam int SEDGE_W   = 31;
  localparam int PROD_W    = 62;
  localparam int XMAG_W    = 61;
  localparam int XLO_W     = 32;
  localparam int XHI_W     = XMAG_W - XLO_W;
  localparam int C2_W      = 124;
  localparam int A2_W      = 64;
  localparam int CROOT_W   = C2_W / 2;
  localparam int CREM_W    = CROOT_W + 2;
  localparam int AROOT_W   = A2_W / 2;
  localparam int AREM_W    = AROOT_W + 2;
  localparam int DMAG_W    = 62;
  localparam int QUO_W     = 32;
  localparam int DREM_W    = 64;
  localparam int VAL_W     = 38;
  localparam int NUM_VALS  = 5;
  localparam int CNT_W     = 4;

  localparam logic [CNT_W-1:0] LAST_ENTRY  = CNT_W'(9);
  localparam logic [CNT_W-1:0] FIRST_IMAG  = CNT_W'(5);

  typedef enum logic [2:0] {
    VS_C_MINUS_A = 3'd0,
    VS_NEG_D     = 3'd1,
    VS_NEG_C     = 3'd2,
    VS_D         = 3'd3,
    VS_A         = 3'd4
  } val_sel_t;

  typedef enum logic [1:0] {
    VX_FIRST  = 2'd0,
    VX_SECOND = 2'd1,
    VX_THIRD  = 2'd2
  } vert_sel_t;

  typedef struct packed {
    logic [ID_W-1:0] id0;
    logic [ID_W-1:0] id1;
    logic [ID_W-1:0] id2;
    logic [1:0]      k;
  } tag_t;

  typedef struct packed {
    tag_t              tag;
    logic              dneg;
    logic [DMAG_W-1:0] dmag;
    logic              degen;
  } side_t;

  typedef struct packed {
    logic [CREM_W-1:0]  rem;
    logic [CROOT_W-1:0] root;
  } csq_t;

  typedef struct packed {
    logic [AREM_W-1:0]  rem;
    logic [AROOT_W-1:0] root;
  } asq_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic              bit_q;
  } dstep_t;

  // One digit of the shift-and-subtract square root on the wide operand.
  function automatic csq_t c_sqrt_step(input csq_t cur, input logic [1:0] pair);
    logic [CREM_W-1:0] r;
    logic [CREM_W-1:0] t;
    csq_t              res;
    r = {cur.rem[CREM_W-3:0], pair};
    t = {cur.root, 2'b01};
    if (r >= t) begin
      res.rem  = r - t;
      res.root = {cur.root[CROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = r;
      res.root = {cur.root[CROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  function automatic asq_t a_sqrt_step(input asq_t cur, input logic [1:0] pair);
    logic [AREM_W-1:0] r;
    logic [AREM_W-1:0] t;
    asq_t              res;
    r = {cur.rem[AREM_W-3:0], pair};
    t = {cur.root, 2'b01};
    if (r >= t) begin
      res.rem  = r - t;
      res.root = {cur.root[AROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = r;
      res.root = {cur.root[AROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // One quotient bit of restoring division; the quotient is known to fit QUO_W bits.
  function automatic dstep_t div_step(input logic [DREM_W-1:0] rem,
                                      input logic [AROOT_W-1:0] dvs, input int sh);
    logic [DREM_W-1:0] shifted;
    dstep_t            res;
    shifted = DREM_W'(dvs) << sh;
    if (rem >= shifted) begin
      res.rem   = rem - shifted;
      res.bit_q = 1'b1;
    end else begin
      res.rem   = rem;
      res.bit_q = 1'b0;
    end
    return res;
  endfunction

  function automatic logic [COEF_W-1:0] sat_coef(input logic signed [VAL_W-1:0] v);
    logic [COEF_W-1:0] res;
    if (v > VAL_W'(signed'(32'h7FFF_FFFF))) begin
      res = 32'h7FFF_FFFF;
    end else if (v < VAL_W'(signed'(32'h8000_0000))) begin
      res = 32'h8000_0000;
    end else begin
      res = v[COEF_W-1:0];
    end
    return res;
  endfunction

  function automatic val_sel_t entry_val(input logic [CNT_W-1:0] idx);
    val_sel_t res;
    case (idx)
      4'd0:    res = VS_C_MINUS_A;
      4'd1:    res = VS_NEG_D;
      4'd2:    res = VS_NEG_C;
      4'd3:    res = VS_D;
      4'd4:    res = VS_A;
      4'd5:    res = VS_D;
      4'd6:    res = VS_C_MINUS_A;
      4'd7:    res = VS_NEG_D;
      4'd8:    res = VS_NEG_C;
      default: res = VS_A;
    endcase
    return res;
  endfunction

  function automatic vert_sel_t entry_vert(input logic [CNT_W-1:0] idx);
    vert_sel_t res;
    case (idx)
      4'd0, 4'd1, 4'd5, 4'd6: res = VX_FIRST;
      4'd2, 4'd3, 4'd7, 4'd8: res = VX_SECOND;
      default:                res = VX_THIRD;
    endcase
    return res;
  endfunction

  function automatic logic entry_is_v(input logic [CNT_W-1:0] idx);
    logic res;
    case (idx)
      4'd1, 4'd3, 4'd6, 4'd8, 4'd9: res = 1'b1;
      default:                      res = 1'b0;
    endcase
    return res;
  endfunction

endpackage

/* sv/lscm_triangle_row_builder.sv */
// Channel | Dir | Handshake          | Content
// s       | in  | s_tvalid, s_tready | one triangle: nine positions and three vertex ids
// m       | out | m_tvalid, m_tready | one coefficient; ten per triangle, tlast on the tenth
//
// Each triangle yields ten transfers on m, one per cycle while m_tready is high. Once the
// output holds a triangle, the single output serialiser lets a new one in only as the
// tenth transfer completes. From s to m a triangle passes nine arithmetic stages, 62
// square root, 33 division and two scaling and saturation stages, and the output register.
// rst is synchronous and clears every stage valid and the serialiser.
// The pipeline moves as one; while m stalls on a held coefficient nothing is lost.
module lscm_triangle_row_builder import lscm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z, third_x, third_y,
  // third_z, first_vertex_id, second_vertex_id, third_vertex_id
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // column, coefficient, zero fill
  output logic [OUT_W-1:0] m_tdata,
  // row_part, degenerate
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  localparam int SQ_STEPS  = CROOT_W;
  localparam int DIV_STEPS = QUO_W;

  logic en;

  logic signed [POS_W-1:0] pos [0:8];
  logic [ID_W-1:0]         vid [0:2];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pos[i] = s_tdata[POS_W*i +: POS_W];
    end
    for (int i = 0; i < 3; i++) begin
      vid[i] = s_tdata[POS_W*9 + ID_W*i +: ID_W];
    end
  end

  // Stage 1: edges.
  logic                     v1;
  logic signed [EDGE_W-1:0] e1 [0:2];
  logic signed [EDGE_W-1:0] e2 [0:2];
  tag_t                     t1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EDGE_W'(pos[3+i]) - EDGE_W'(pos[i]);
        e2[i] <= EDGE_W'(pos[6+i]) - EDGE_W'(pos[i]);
      end
      t1 <= '{id0: vid[0], id1: vid[1], id2: vid[2], k: 2'd0};
    end
  end

  // Stage 2: magnitudes and signs.
  logic              v2;
  logic [EDGE_W-1:0] mg [0:5];
  logic              sg [0:5];
  tag_t              t2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mg[i]   <= e1[i][EDGE_W-1] ? EDGE_W'(-e1[i]) : EDGE_W'(e1[i]);
        mg[3+i] <= e2[i][EDGE_W-1] ? EDGE_W'(-e2[i]) : EDGE_W'(e2[i]);
        sg[i]   <= e1[i][EDGE_W-1];
        sg[3+i] <= e2[i][EDGE_W-1];
      end
      t2 <= t1;
    end
  end

  // Stage 3: scale down so that every component stays below 2^30.
  logic                      v3;
  logic signed [SEDGE_W-1:0] se [0:5];
  tag_t                      t3;
  logic                      any32, any31, any30;
  logic [1:0]                kk;

  always_comb begin
    any32 = 1'b0;
    any31 = 1'b0;
    any30 = 1'b0;
    for (int j = 0; j < 6; j++) begin
      any32 = any32 | mg[j][32];
      any31 = any31 | mg[j][31];
      any30 = any30 | mg[j][30];
    end
    kk = any32 ? 2'd3 : any31 ? 2'd2 : any30 ? 2'd1 : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 6; j++) begin
        se[j] <= sg[j] ? -SEDGE_W'(mg[j] >> kk) : SEDGE_W'(mg[j] >> kk);
      end
      t3 <= '{id0: t2.id0, id1: t2.id1, id2: t2.id2, k: kk};
    end
  end

  // Stage 4: products.
  logic                     v4;
  logic signed [PROD_W-1:0] psq [0:2];
  logic signed [PROD_W-1:0] pdt [0:2];
  logic signed [PROD_W-1:0] pa  [0:2];
  logic signed [PROD_W-1:0] pb  [0:2];
  tag_t                     t4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        psq[i] <= PROD_W'(se[i]) * PROD_W'(se[i]);
        pdt[i] <= PROD_W'(se[i]) * PROD_W'(se[3+i]);
        pa[i]  <= PROD_W'(se[(i+1)%3]) * PROD_W'(se[3+(i+2)%3]);
        pb[i]  <= PROD_W'(se[(i+2)%3]) * PROD_W'(se[3+(i+1)%3]);
      end
      t4 <= t3;
    end
  end

  // Stage 5: sums and cross product.
  logic                     v5;
  logic [A2_W-1:0]          a2_5;
  logic signed [A2_W-1:0]   dot5;
  logic signed [PROD_W-1:0] x5 [0:2];
  tag_t                     t5;

  always_ff @(posedge clk) begin
    if (en) begin
      a2_5 <= A2_W'(psq[0]) + A2_W'(psq[1]) + A2_W'(psq[2]);
      dot5 <= A2_W'(pdt[0]) + A2_W'(pdt[1]) + A2_W'(pdt[2]);
      for (int i = 0; i < 3; i++) begin
        x5[i] <= pa[i] - pb[i];
      end
      t5 <= t4;
    end
  end

  // Stage 6: magnitudes of the dot and cross products.
  logic              v6;
  logic [A2_W-1:0]   a2_6;
  logic              dneg6;
  logic [DMAG_W-1:0] dmag6;
  logic [XMAG_W-1:0] xm6 [0:2];
  logic              degen6;
  tag_t              t6;

  always_ff @(posedge clk) begin
    if (en) begin
      a2_6   <= a2_5;
      dneg6  <= dot5[A2_W-1];
      dmag6  <= dot5[A2_W-1] ? DMAG_W'(-dot5) : DMAG_W'(dot5);
      for (int i = 0; i < 3; i++) begin
        xm6[i] <= x5[i][PROD_W-1] ? XMAG_W'(-x5[i]) : XMAG_W'(x5[i]);
      end
      degen6 <= (x5[0] == '0) && (x5[1] == '0) && (x5[2] == '0);
      t6     <= t5;
    end
  end

  // Stage 7: partial products of the squared cross components.
  logic                       v7;
  side_t                      sd7;
  logic [A2_W-1:0]            a2_7;
  logic [2*XHI_W-1:0]         hh [0:2];
  logic [XHI_W+XLO_W-1:0]     hl [0:2];
  logic [2*XLO_W-1:0]         ll [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh[i] <= (2*XHI_W)'(xm6[i][XMAG_W-1:XLO_W]) * (2*XHI_W)'(xm6[i][XMAG_W-1:XLO_W]);
        hl[i] <= (XHI_W+XLO_W)'(xm6[i][XMAG_W-1:XLO_W]) *
                 (XHI_W+XLO_W)'(xm6[i][XLO_W-1:0]);
        ll[i] <= (2*XLO_W)'(xm6[i][XLO_W-1:0]) * (2*XLO_W)'(xm6[i][XLO_W-1:0]);
      end
      a2_7 <= a2_6;
      sd7  <= '{tag: t6, dneg: dneg6, dmag: dmag6, degen: degen6};
    end
  end

  // Stage 8: squared cross components.
  logic            v8;
  side_t           sd8;
  logic [A2_W-1:0] a2_8;
  logic [C2_W-1:0] sq8 [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq8[i] <= (C2_W'(hh[i]) << (2*XLO_W)) + (C2_W'(hl[i]) << (XLO_W+1)) + C2_W'(ll[i]);
      end
      a2_8 <= a2_7;
      sd8  <= sd7;
    end
  end

  // Stage 9 is entry zero of the square root line.
  logic            qv  [0:SQ_STEPS];
  side_t           qs  [0:SQ_STEPS];
  logic [C2_W-1:0] cop [0:SQ_STEPS];
  csq_t            cst [0:SQ_STEPS];
  logic [A2_W-1:0] aop [0:SQ_STEPS];
  asq_t            ast [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      cop[0] <= sq8[0] + sq8[1] + sq8[2];
      cst[0] <= '0;
      aop[0] <= a2_8;
      ast[0] <= '0;
      qs[0]  <= sd8;
      for (int j = 0; j < SQ_STEPS; j++) begin
        cst[j+1] <= c_sqrt_step(cst[j], cop[j][C2_W-1 -: 2]);
        cop[j+1] <= cop[j] << 2;
        if (j < AROOT_W) begin
          ast[j+1] <= a_sqrt_step(ast[j], aop[j][A2_W-1 -: 2]);
        end else begin
          ast[j+1] <= ast[j];
        end
        aop[j+1] <= aop[j] << 2;
        qs[j+1]  <= qs[j];
      end
    end
  end

  // Division line: entry zero takes the roots, then one quotient bit a stage.
  logic               dv  [0:DIV_STEPS];
  side_t              ds  [0:DIV_STEPS];
  logic [AROOT_W-1:0] dau [0:DIV_STEPS];
  logic [DREM_W-1:0]  dr1 [0:DIV_STEPS];
  logic [DREM_W-1:0]  dr2 [0:DIV_STEPS];
  logic [QUO_W-1:0]   dq1 [0:DIV_STEPS];
  logic [QUO_W-1:0]   dq2 [0:DIV_STEPS];
  dstep_t             st1 [0:DIV_STEPS-1];
  dstep_t             st2 [0:DIV_STEPS-1];

  always_comb begin
    for (int j = 0; j < DIV_STEPS; j++) begin
      st1[j] = div_step(dr1[j], dau[j], DIV_STEPS-1-j);
      st2[j] = div_step(dr2[j], dau[j], DIV_STEPS-1-j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0]  <= qs[SQ_STEPS];
      dau[0] <= ast[SQ_STEPS].root;
      dr1[0] <= DREM_W'(qs[SQ_STEPS].dmag);
      dr2[0] <= DREM_W'(cst[SQ_STEPS].root);
      dq1[0] <= '0;
      dq2[0] <= '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        ds[j+1]  <= ds[j];
        dau[j+1] <= dau[j];
        dr1[j+1] <= st1[j].rem;
        dr2[j+1] <= st2[j].rem;
        dq1[j+1] <= {dq1[j][QUO_W-2:0], st1[j].bit_q};
        dq2[j+1] <= {dq2[j][QUO_W-2:0], st2[j].bit_q};
      end
    end
  end

  // Final stage one: undo the scaling and form the five distinct values.
  logic                    fv1;
  side_t                   fs1;
  logic signed [VAL_W-1:0] fval [0:NUM_VALS-1];
  logic signed [VAL_W-1:0] av, cv, dvv;

  always_comb begin
    av  = VAL_W'(dau[DIV_STEPS]) << ds[DIV_STEPS].tag.k;
    dvv = VAL_W'(dq2[DIV_STEPS]) << ds[DIV_STEPS].tag.k;
    cv  = VAL_W'(dq1[DIV_STEPS]) << ds[DIV_STEPS].tag.k;
    if (ds[DIV_STEPS].dneg) begin
      cv = -cv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fval[VS_C_MINUS_A] <= cv - av;
      fval[VS_NEG_D]     <= -dvv;
      fval[VS_NEG_C]     <= -cv;
      fval[VS_D]         <= dvv;
      fval[VS_A]         <= av;
      fs1                <= ds[DIV_STEPS];
    end
  end

  // Final stage two: saturation.
  logic              fv2;
  side_t             fs2;
  logic [COEF_W-1:0] fsat [0:NUM_VALS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_VALS; i++) begin
        fsat[i] <= sat_coef(fval[i]);
      end
      fs2 <= fs1;
    end
  end

  // Output serialiser: ten transfers per triangle.
  logic              ov;
  logic [CNT_W-1:0]  cnt;
  tag_t              otag;
  logic              odeg;
  logic [COEF_W-1:0] osat [0:NUM_VALS-1];

  assign en       = !ov || (m_tready && (cnt == LAST_ENTRY));
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
      v5  <= 1'b0;
      v6  <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      fv1 <= 1'b0;
      fv2 <= 1'b0;
      ov  <= 1'b0;
      cnt <= '0;
      for (int j = 0; j <= SQ_STEPS; j++) begin
        qv[j] <= 1'b0;
      end
      for (int j = 0; j <= DIV_STEPS; j++) begin
        dv[j] <= 1'b0;
      end
    end else if (en) begin
      v1    <= s_tvalid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      v6    <= v5;
      v7    <= v6;
      v8    <= v7;
      qv[0] <= v8;
      for (int j = 0; j < SQ_STEPS; j++) begin
        qv[j+1] <= qv[j];
      end
      dv[0] <= qv[SQ_STEPS];
      for (int j = 0; j < DIV_STEPS; j++) begin
        dv[j+1] <= dv[j];
      end
      fv1 <= dv[DIV_STEPS];
      fv2 <= fv1;
      ov  <= fv2;
      cnt <= '0;
    end else if (m_tready) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      otag <= fs2.tag;
      odeg <= fs2.degen;
      for (int i = 0; i < NUM_VALS; i++) begin
        osat[i] <= fsat[i];
      end
    end
  end

  logic [ID_W-1:0]   cur_id;
  logic [COL_W-1:0]  cur_col;
  logic [COEF_W-1:0] cur_coef;
  val_sel_t          cur_sel;

  always_comb begin
    case (entry_vert(cnt))
      VX_FIRST:  cur_id = otag.id0;
      VX_SECOND: cur_id = otag.id1;
      default:   cur_id = otag.id2;
    endcase
    cur_col  = {cur_id, entry_is_v(cnt)};
    cur_sel  = entry_val(cnt);
    cur_coef = odeg ? '0 : osat[cur_sel];
  end

  assign m_tvalid = ov;
  assign m_tdata  = {(OUT_W-COL_W-COEF_W)'(0), cur_coef, cur_col};
  assign m_tuser  = {odeg, (cnt >= FIRST_IMAG)};
  assign m_tlast  = (cnt == LAST_ENTRY);

endmodule
